@@ rtl/tlst_pkg.sv @@
// ----------------------------------------------------------------------------
// tlst_pkg
// shared constants and codes for the timestamp lru slot table
// ----------------------------------------------------------------------------
package tlst_pkg;

  // table geometry
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // field widths
  localparam int KEY_W  = 32;
  localparam int TIME_W = 32;
  localparam int SLOT_W = 4;

  // configuration register
  localparam int               CFG_W     = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // apb port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int REG_W   = PADDR_W - 2;

  // register indexes
  localparam logic [REG_W-1:0] REG_ENTRIES_IN_USE = 1'b0;

  // request opcodes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

endpackage

@@ rtl/tlst_req_if.sv @@
// ----------------------------------------------------------------------------
// tlst_req_if
// request channel: opcode, key and use time with valid/ready
// ----------------------------------------------------------------------------
interface tlst_req_if;
  import tlst_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [KEY_W-1:0]  key;
  logic [TIME_W-1:0] use_time;

  modport source (output valid, output opcode, output key, output use_time, input ready);
  modport sink   (input valid, input opcode, input key, input use_time, output ready);
endinterface

@@ rtl/tlst_rsp_if.sv @@
// ----------------------------------------------------------------------------
// tlst_rsp_if
// response channel: hit, slot and eviction report with valid/ready
// ----------------------------------------------------------------------------
interface tlst_rsp_if;
  import tlst_pkg::*;

  logic              valid;
  logic              ready;
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic              evicted;
  logic [KEY_W-1:0]  evicted_key;

  modport source (output valid, output hit, output slot, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input slot, input evicted,
                  input evicted_key, output ready);
endinterface

@@ rtl/timestamp_lru_slot_table.sv @@
// ----------------------------------------------------------------------------
// timestamp_lru_slot_table
// requests: one in flight at a time; the slot scan reads one key/time entry
//   per cycle through a single comparator
// reset: synchronous, clears all valid bits, sets entries_in_use to 16
// ----------------------------------------------------------------------------
module timestamp_lru_slot_table (
  input  logic                          clk,
  input  logic                          rst,
  tlst_req_if.sink                      req,
  tlst_rsp_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlst_pkg::PADDR_W-1:0]  paddr,
  input  logic [tlst_pkg::PDATA_W-1:0]  pwdata,
  output logic [tlst_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import tlst_pkg::*;

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  // configuration
  logic [CFG_W-1:0] entries_in_use;
  logic [REG_W-1:0] reg_idx;
  logic             cfg_wr;
  logic [CNT_W-1:0] n_act;

  // slot storage: valid bits in flops, key and time in memories
  logic [MAX_ENTRIES-1:0] slot_valid;
  logic [KEY_W-1:0]       slot_key  [MAX_ENTRIES];
  logic [TIME_W-1:0]      slot_time [MAX_ENTRIES];

  // sequencer
  logic [1:0]       state;
  logic [CNT_W-1:0] rd_idx;
  logic             ev_pend;
  logic [IDX_W-1:0] ev_idx;
  logic             last_eval;
  logic             req_take;

  // latched request
  logic              req_op;
  logic [KEY_W-1:0]  req_key;
  logic [TIME_W-1:0] req_time;

  // registered memory read data
  logic [KEY_W-1:0]  rd_key;
  logic [TIME_W-1:0] rd_time;

  // scan results
  logic              hit_found;
  logic [IDX_W-1:0]  match_idx;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic [IDX_W-1:0]  best_idx;
  logic [TIME_W-1:0] best_time;
  logic [KEY_W-1:0]  best_key;

  // shared comparator
  logic [KEY_W-1:0] cmp_a;
  logic [KEY_W-1:0] cmp_b;
  logic [KEY_W:0]   cmp_diff;
  logic             cmp_eq;
  logic             cmp_lt;
  logic             ev_slot_valid;

  logic [IDX_W-1:0] wr_idx;

  // --------------------------------------------------------------------------
  // apb register: one register, index taken from the word address
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && (reg_idx == REG_ENTRIES_IN_USE);

  always_comb begin
    if (reg_idx == REG_ENTRIES_IN_USE) begin
      prdata = PDATA_W'(entries_in_use);
    end else begin
      prdata = '0;
    end
  end

  // zero acts as one, anything above the table size is clamped
  always_comb begin
    if (entries_in_use == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(entries_in_use) > 32'(MAX_ENTRIES)) begin
      n_act = CNT_W'(MAX_ENTRIES);
    end else begin
      n_act = CNT_W'(entries_in_use);
    end
  end

  // --------------------------------------------------------------------------
  // handshake: a new request may enter in the same cycle the previous
  // response transfers out
  // --------------------------------------------------------------------------
  assign req.ready = (state == ST_IDLE) && (!rsp.valid || rsp.ready);
  assign req_take  = req.valid && req.ready;

  // --------------------------------------------------------------------------
  // shared compare unit
  // lookup: equality of stored key against request key
  // insert: stored time below the oldest time seen so far
  // --------------------------------------------------------------------------
  assign cmp_a         = (req_op == OP_INSERT) ? rd_time : rd_key;
  assign cmp_b         = (req_op == OP_INSERT) ? best_time : req_key;
  assign cmp_diff      = {1'b0, cmp_a} - {1'b0, cmp_b};
  assign cmp_eq        = (cmp_diff[KEY_W-1:0] == '0);
  assign cmp_lt        = cmp_diff[KEY_W];
  assign ev_slot_valid = slot_valid[ev_idx];

  // last slot of the active range is being evaluated
  assign last_eval = (CNT_W'(ev_idx) == n_act - CNT_W'(1));

  // lowest empty slot wins, else the oldest one
  assign wr_idx = free_found ? free_idx : best_idx;

  // --------------------------------------------------------------------------
  // control: sequencer, valid bits, response valid, configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      rd_idx         <= '0;
      ev_pend        <= 1'b0;
      slot_valid     <= '0;
      rsp.valid      <= 1'b0;
      entries_in_use <= CFG_RESET;
    end else begin
      if (cfg_wr) begin
        entries_in_use <= pwdata[CFG_W-1:0];
      end
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_take) begin
            rd_idx  <= '0;
            ev_pend <= 1'b0;
            state   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // issue one memory read per cycle, evaluate it in the following cycle
          if (rd_idx < n_act) begin
            ev_pend <= 1'b1;
            rd_idx  <= rd_idx + CNT_W'(1);
          end else begin
            ev_pend <= 1'b0;
          end
          if (ev_pend && last_eval) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (req_op == OP_INSERT) begin
            slot_valid[wr_idx] <= 1'b1;
          end
          rsp.valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // datapath: request latch, scan bookkeeping, response payload
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (req_take) begin
      req_op     <= req.opcode;
      req_key    <= req.key;
      req_time   <= req.use_time;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end

    if (state == ST_SCAN && rd_idx < n_act) begin
      ev_idx <= rd_idx[IDX_W-1:0];
    end

    if (state == ST_SCAN && ev_pend) begin
      if (req_op == OP_LOOKUP) begin
        if (!hit_found && ev_slot_valid && cmp_eq) begin
          hit_found <= 1'b1;
          match_idx <= ev_idx;
        end
      end else begin
        if (!free_found && !ev_slot_valid) begin
          free_found <= 1'b1;
          free_idx   <= ev_idx;
        end
        // strict compare keeps the lowest index on a tie
        if (ev_idx == '0 || cmp_lt) begin
          best_idx  <= ev_idx;
          best_time <= rd_time;
          best_key  <= rd_key;
        end
      end
    end

    if (state == ST_WRITE) begin
      if (req_op == OP_LOOKUP) begin
        rsp.hit         <= hit_found;
        rsp.slot        <= hit_found ? SLOT_W'(match_idx) : '0;
        rsp.evicted     <= 1'b0;
        rsp.evicted_key <= '0;
      end else begin
        rsp.hit         <= 1'b0;
        rsp.slot        <= SLOT_W'(wr_idx);
        rsp.evicted     <= !free_found;
        rsp.evicted_key <= free_found ? '0 : best_key;
      end
    end
  end

  // --------------------------------------------------------------------------
  // key and time memories: one write port, one registered read port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == ST_WRITE && req_op == OP_INSERT) begin
      slot_key[wr_idx]  <= req_key;
      slot_time[wr_idx] <= req_time;
    end
    rd_key  <= slot_key[rd_idx[IDX_W-1:0]];
    rd_time <= slot_time[rd_idx[IDX_W-1:0]];
  end

`ifndef NO_ASSERTIONS
  // a response only waits while the sequencer is idle
  a_rsp_only_idle: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> state == ST_IDLE)
    else $error("response pending outside idle");

  // a response appears only after the write step
  a_rsp_after_write: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == ST_WRITE)
    else $error("response raised without write step");

  // a hit and an eviction never come together
  a_hit_not_evict: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.hit && rsp.evicted))
    else $error("hit and eviction in one response");

  // an inserted slot is valid afterward
  a_insert_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE && req_op == OP_INSERT) |=> slot_valid[$past(wr_idx)])
    else $error("inserted slot not marked valid");

  // the scan never runs past the active range
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> rd_idx <= n_act)
    else $error("scan index beyond active slots");
`endif

endmodule

@@ tb/timestamp_lru_slot_table_tb.sv @@
// ----------------------------------------------------------------------------
// timestamp_lru_slot_table_tb
// self-checking bench: a shadow copy of the slot table predicts every response,
// requests and responses stall at random, and the active slot count is swept
// ----------------------------------------------------------------------------
module timestamp_lru_slot_table_tb;
  import tlst_pkg::*;

  // index one past the register list, writes there must be dropped
  localparam logic [REG_W-1:0] REG_UNMAPPED = 1'b1;
  localparam int KEY_POOL  = 20;
  localparam int IDLE_PCT  = 38;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic              opcode;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] use_time;
    logic              drain;     // hold this request until every response is back
  } request_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
  } response_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  tlst_req_if req_ch ();
  tlst_rsp_if rsp_ch ();

  timestamp_lru_slot_table i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // requests waiting for the driver, and responses the shadow table has predicted
  request_t  pending_req[$];
  response_t expected_rsp[$];
  request_t  in_flight;

  // shadow copy of the slot table and of the slot count register
  logic              shadow_valid [MAX_ENTRIES];
  logic [KEY_W-1:0]  shadow_key   [MAX_ENTRIES];
  logic [TIME_W-1:0] shadow_time  [MAX_ENTRIES];
  logic [CFG_W-1:0]  shadow_limit;

  logic [KEY_W-1:0]  key_pool [KEY_POOL];
  logic [TIME_W-1:0] stamp_clock;
  bit                steady;      // no idling on either side while set
  int                error_count;

  // 2 time unit period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_SHOWN) begin
      $display("%s", msg);
    end
  endtask

  // one request against the shadow table: lookups only read, inserts fill the
  // lowest empty slot or replace the oldest stamp (lowest index on a tie)
  function automatic response_t apply_request(input request_t r);
    int        n;
    int        best;
    bit        found;
    response_t res;
    res   = '0;
    found = 1'b0;
    best  = 0;
    n     = int'(shadow_limit);
    if (n < 1) n = 1;
    if (n > MAX_ENTRIES) n = MAX_ENTRIES;
    if (r.opcode == OP_LOOKUP) begin
      for (int i = 0; i < n; i++) begin
        if (!found && shadow_valid[i] && shadow_key[i] == r.key) begin
          found    = 1'b1;
          res.hit  = 1'b1;
          res.slot = SLOT_W'(i);
        end
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        if (!found && !shadow_valid[i]) begin
          found = 1'b1;
          best  = i;
        end
      end
      if (!found) begin
        // table full over the active range, pick the oldest stamp
        for (int i = 1; i < n; i++) begin
          if (shadow_time[i] < shadow_time[best]) best = i;
        end
        res.evicted     = 1'b1;
        res.evicted_key = shadow_key[best];
      end
      res.slot          = SLOT_W'(best);
      shadow_valid[best] = 1'b1;
      shadow_key[best]   = r.key;
      shadow_time[best]  = r.use_time;
    end
    return res;
  endfunction

  // request driver: a request stays up until its transfer, then the next one
  // may follow in the same cycle or after a random gap
  always @(posedge clk) begin : drive_requests
    if (rst) begin
      req_ch.valid    <= 1'b0;
      req_ch.opcode   <= OP_LOOKUP;
      req_ch.key      <= '0;
      req_ch.use_time <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_rsp.push_back(apply_request(in_flight));
      end
      if (!(req_ch.valid && !req_ch.ready)) begin
        if (pending_req.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT) &&
            !(pending_req[0].drain && expected_rsp.size() != 0)) begin
          in_flight = pending_req.pop_front();
          req_ch.valid    <= 1'b1;
          req_ch.opcode   <= in_flight.opcode;
          req_ch.key      <= in_flight.key;
          req_ch.use_time <= in_flight.use_time;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor: every transfer is checked field by field against the
  // oldest prediction, ready toggles at random unless steady is set
  always @(posedge clk) begin : check_responses
    response_t got;
    response_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = '{rsp_ch.hit, rsp_ch.slot, rsp_ch.evicted, rsp_ch.evicted_key};
        if (expected_rsp.size() == 0) begin
          flag_error($sformatf("unexpected response hit=%0b slot=%0d evicted=%0b key=%h",
                               got.hit, got.slot, got.evicted, got.evicted_key));
        end else begin
          want = expected_rsp.pop_front();
          if (got.hit !== want.hit || got.slot !== want.slot ||
              got.evicted !== want.evicted || got.evicted_key !== want.evicted_key) begin
            flag_error($sformatf({"response mismatch: expected hit=%0b slot=%0d ",
                                  "evicted=%0b key=%h, got hit=%0b slot=%0d ",
                                  "evicted=%0b key=%h"},
                                 want.hit, want.slot, want.evicted, want.evicted_key,
                                 got.hit, got.slot, got.evicted, got.evicted_key));
          end
        end
      end
      rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // apb write: setup then access, the register updates at the access edge
  task automatic write_reg(input logic [REG_W-1:0] idx, input logic [CFG_W-1:0] value);
    logic [PDATA_W-1:0] data;
    // random upper bits, only the low bits of the register are kept
    data = $urandom();
    data[CFG_W-1:0] = value;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_ENTRIES_IN_USE) shadow_limit = value;
  endtask

  task automatic queue_req(input logic op, input logic [KEY_W-1:0] key,
                           input logic [TIME_W-1:0] stamp);
    request_t r;
    r.opcode   = op;
    r.key      = key;
    r.use_time = stamp;
    r.drain    = 1'b0;
    pending_req.push_back(r);
  endtask

  // all requests sent, all responses back, then an idle wait before returning
  // so the block has finished its writeback before any register write
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_req.size() != 0 || req_ch.valid || expected_rsp.size() != 0);
    repeat (MAX_ENTRIES + 4) @(posedge clk);
  endtask

  // random traffic: keys mostly from a small pool so lookups hit and inserts
  // collide, stamps mixed between a rising clock, ties, extremes and noise
  task automatic random_phase(input logic [CFG_W-1:0] limit, input int count,
                              input bit drain_mid);
    request_t r;
    int       pick;
    wait_quiet();
    write_reg(REG_ENTRIES_IN_USE, limit);
    for (int k = 0; k < count; k++) begin
      r.opcode = ($urandom_range(1) == 0) ? OP_LOOKUP : OP_INSERT;
      pick = $urandom_range(99);
      if (pick < 65)      r.key = key_pool[$urandom_range(KEY_POOL - 1)];
      else if (pick < 70) r.key = ($urandom_range(1) == 0) ? '0 : '1;
      else                r.key = $urandom();
      pick = $urandom_range(99);
      if (pick < 40) begin
        stamp_clock += TIME_W'($urandom_range(1, 3));
        r.use_time = stamp_clock;
      end else if (pick < 70) begin
        r.use_time = TIME_W'($urandom_range(7));
      end else if (pick < 80) begin
        r.use_time = ($urandom_range(1) == 0) ? '0 : '1;
      end else begin
        r.use_time = $urandom();
      end
      r.drain = drain_mid && (k == count / 2);
      pending_req.push_back(r);
    end
  endtask

  initial begin : stimulus
    rst          = 1'b1;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    error_count  = 0;
    steady       = 1'b0;
    stamp_clock  = '0;
    shadow_limit = CFG_RESET;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i]   = '0;
      shadow_time[i]  = '0;
    end
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table at the reset slot count: miss, extreme keys and stamps,
    // duplicate key takes a second slot, lookup ignores use_time
    queue_req(OP_LOOKUP, '0, '0);
    queue_req(OP_INSERT, '0, '1);
    queue_req(OP_INSERT, '1, '0);
    queue_req(OP_INSERT, '0, 32'd5);
    queue_req(OP_LOOKUP, '0, '1);
    queue_req(OP_LOOKUP, '1, '0);
    queue_req(OP_LOOKUP, 32'hA5A5_5A5A, '0);
    wait_quiet();

    // single slot: slot 0 is full so the insert evicts, slot 1 drops out of view
    write_reg(REG_ENTRIES_IN_USE, 5'd1);
    queue_req(OP_INSERT, 32'h1234_5678, 32'd7);
    queue_req(OP_LOOKUP, '1, '0);
    wait_quiet();

    // zero acts like one slot
    write_reg(REG_ENTRIES_IN_USE, 5'd0);
    queue_req(OP_INSERT, 32'h8765_4321, 32'd7);
    wait_quiet();

    // above the table size clamps to sixteen, hidden slots come back intact
    write_reg(REG_ENTRIES_IN_USE, 5'd31);
    queue_req(OP_LOOKUP, '1, '0);
    queue_req(OP_LOOKUP, '0, '0);
    wait_quiet();

    // three full slots: oldest stamp goes, equal stamps go lowest index first
    write_reg(REG_ENTRIES_IN_USE, 5'd3);
    queue_req(OP_INSERT, 32'hDEAD_BEEF, 32'd5);
    queue_req(OP_INSERT, 32'hCAFE_F00D, 32'd9);
    queue_req(OP_INSERT, 32'h0F0F_0F0F, '1);
    wait_quiet();

    // write outside the register list must leave the slot count alone
    write_reg(REG_UNMAPPED, 5'd16);
    queue_req(OP_INSERT, 32'h5555_AAAA, 32'd1);
    queue_req(OP_LOOKUP, 32'hCAFE_F00D, '0);

    // long stretch without idling on either side
    steady = 1'b1;
    random_phase(5'd16, 150, 1'b0);
    wait_quiet();
    steady = 1'b0;

    // random gaps from here on, one drain pause in the middle of this phase
    random_phase(5'd16, 200, 1'b1);
    random_phase(5'd1, 60, 1'b0);
    random_phase(5'd0, 40, 1'b0);
    random_phase(5'd31, 80, 1'b1);
    random_phase(5'd2, 60, 1'b0);
    random_phase(5'd4, 80, 1'b0);
    for (int p = 0; p < 4; p++) begin
      random_phase(CFG_W'($urandom_range(1, MAX_ENTRIES)), 40, 1'b0);
    end
    random_phase(5'd16, 60, 1'b0);

    // drain: wait for the last transfer, then a bounded wait for responses
    do @(negedge clk);
    while (pending_req.size() != 0 || req_ch.valid);
    for (int c = 0; c < 4000 && expected_rsp.size() != 0; c++) @(negedge clk);
    repeat (MAX_ENTRIES + 4) @(posedge clk);
    if (expected_rsp.size() != 0) begin
      flag_error($sformatf("%0d responses never arrived", expected_rsp.size()));
    end

    if (error_count == 0) begin
      $display("timestamp_lru_slot_table_tb: done, clean");
    end else begin
      $display("timestamp_lru_slot_table_tb: done, errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #1000000;
    $display("timestamp_lru_slot_table_tb: done, errors");
    $finish;
  end

endmodule
